// ===== rtl/hh4df_pkg.sv =====
// shared types and constants for the hci h4 deframer with event filter
// no dependencies
`timescale 1ns / 1ps

package hh4df_pkg;

    typedef enum logic [1:0] {
        KIND_JUNK = 2'd0,
        KIND_EVT  = 2'd1,
        KIND_ACL  = 2'd2,
        KIND_ISO  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        V_DELIVER = 2'd0,
        V_DISCARD = 2'd1,
        V_DROP    = 2'd2
    } t_verdict;

    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      frame_kind;
        logic       first_of_frame;
        logic       last_of_frame;
        t_verdict   verdict;
        logic       recovery_request;
    } t_result;

    localparam logic [7:0]  TYPE_EVT      = 8'h04;
    localparam logic [7:0]  TYPE_ACL      = 8'h02;
    localparam logic [7:0]  TYPE_ISO      = 8'h05;

    localparam logic [7:0]  EVC_HW_ERROR  = 8'h10;
    localparam logic [7:0]  EVC_CMD_COMP  = 8'h0E;
    localparam logic [7:0]  EVC_LE_META   = 8'h3E;
    localparam logic [15:0] OPC_NOP       = 16'h0000;
    localparam logic [15:0] OPC_READ_FEAT = 16'h1003;
    localparam logic [7:0]  FEAT_PATCH    = 8'h60;
    localparam logic [7:0]  STATUS_OK     = 8'h00;

    localparam logic [3:0]  IDX_SUBEVENT  = 4'd0;
    localparam logic [3:0]  IDX_OP_LSB    = 4'd1;
    localparam logic [3:0]  IDX_OP_MSB    = 4'd2;
    localparam logic [3:0]  IDX_STATUS    = 4'd3;
    localparam logic [3:0]  IDX_FEAT4     = 4'd8;
    localparam logic [3:0]  IDX_MAX       = 4'd15;

    localparam logic [2:0]  HDR_CODE      = 3'd0;
    localparam logic [2:0]  HDR_LEN_LO    = 3'd2;
    localparam logic [2:0]  HDR_LEN_HI    = 3'd3;

    // advertising and scan report subevents
    function automatic logic is_discardable(input logic [7:0] s);
        is_discardable = (s == 8'h0B) || (s == 8'h13) || (s == 8'h0D) ||
                         (s == 8'h0F) || (s == 8'h25);
    endfunction

endpackage

// ===== rtl/hh4df_parser.sv =====
// h4 frame parser: per-byte parse state, event filter and feature patch
// depends on hh4df_pkg
`timescale 1ns / 1ps

module hh4df_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    output hh4df_pkg::t_result o_result
);

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_HEADER,
        PH_PAYLOAD
    } t_phase;

    t_phase               r_phase,     n_phase;
    hh4df_pkg::t_kind     r_kind,      n_kind;
    logic [2:0]           r_hdr_idx,   n_hdr_idx;
    logic [7:0]           r_len_lo,    n_len_lo;
    logic [15:0]          r_remaining, n_remaining;
    logic [3:0]           r_pay_idx,   n_pay_idx;
    logic [7:0]           r_evt_code,  n_evt_code;
    logic [15:0]          r_opcode,    n_opcode;
    logic [7:0]           r_status,    n_status;
    hh4df_pkg::t_verdict  r_verdict,   n_verdict;
    logic                 r_rec_en;

    logic                 hdr_done;
    logic [15:0]          len;
    hh4df_pkg::t_result   res;

    always_comb begin
        n_phase     = r_phase;
        n_kind      = r_kind;
        n_hdr_idx   = r_hdr_idx;
        n_len_lo    = r_len_lo;
        n_remaining = r_remaining;
        n_pay_idx   = r_pay_idx;
        n_evt_code  = r_evt_code;
        n_opcode    = r_opcode;
        n_status    = r_status;
        n_verdict   = r_verdict;
        hdr_done    = 1'b0;
        len         = 16'd0;

        res                  = '0;
        res.out_byte         = i_byte;
        res.frame_kind       = hh4df_pkg::KIND_JUNK;
        res.verdict          = hh4df_pkg::V_DELIVER;

        case (r_phase)
            PH_HEADER: begin
                res.frame_kind = r_kind;
                if (r_kind == hh4df_pkg::KIND_EVT) begin
                    if (r_hdr_idx == hh4df_pkg::HDR_CODE) begin
                        n_evt_code = i_byte;
                        n_verdict  = (i_byte == hh4df_pkg::EVC_HW_ERROR && r_rec_en) ?
                                     hh4df_pkg::V_DROP : hh4df_pkg::V_DELIVER;
                    end else begin
                        len      = {8'd0, i_byte};
                        hdr_done = 1'b1;
                    end
                end else begin
                    if (r_hdr_idx == hh4df_pkg::HDR_LEN_LO) begin
                        n_len_lo = i_byte;
                    end else if (r_hdr_idx >= hh4df_pkg::HDR_LEN_HI) begin
                        len = {i_byte, r_len_lo};
                        if (r_kind == hh4df_pkg::KIND_ISO) begin
                            len[15:14] = 2'b00;
                        end
                        hdr_done = 1'b1;
                    end
                end
                n_hdr_idx = r_hdr_idx + 3'd1;
                if (hdr_done) begin
                    n_remaining = len;
                    n_pay_idx   = '0;
                    if (len == 16'd0) begin
                        res.last_of_frame = 1'b1;
                        n_phase           = PH_TYPE;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                res.frame_kind = r_kind;
                if (r_kind == hh4df_pkg::KIND_EVT) begin
                    if (r_evt_code == hh4df_pkg::EVC_LE_META &&
                        r_pay_idx == hh4df_pkg::IDX_SUBEVENT) begin
                        if (hh4df_pkg::is_discardable(i_byte)) begin
                            n_verdict = hh4df_pkg::V_DISCARD;
                        end
                    end else if (r_evt_code == hh4df_pkg::EVC_CMD_COMP) begin
                        if (r_pay_idx == hh4df_pkg::IDX_OP_LSB) begin
                            n_opcode = {r_opcode[15:8], i_byte};
                        end else if (r_pay_idx == hh4df_pkg::IDX_OP_MSB) begin
                            n_opcode = {i_byte, r_opcode[7:0]};
                            if ({i_byte, r_opcode[7:0]} == hh4df_pkg::OPC_NOP) begin
                                n_verdict = hh4df_pkg::V_DROP;
                            end
                        end else if (r_pay_idx == hh4df_pkg::IDX_STATUS) begin
                            n_status = i_byte;
                        end else if (r_pay_idx == hh4df_pkg::IDX_FEAT4 &&
                                     r_opcode == hh4df_pkg::OPC_READ_FEAT &&
                                     r_status == hh4df_pkg::STATUS_OK) begin
                            res.out_byte = i_byte | hh4df_pkg::FEAT_PATCH;
                        end
                    end
                end
                if (r_pay_idx != hh4df_pkg::IDX_MAX) begin
                    n_pay_idx = r_pay_idx + 4'd1;
                end
                n_remaining = r_remaining - 16'd1;
                if (n_remaining == 16'd0) begin
                    res.last_of_frame = 1'b1;
                    n_phase           = PH_TYPE;
                end
            end
            default: begin
                n_phase = PH_TYPE;
                if (i_byte == hh4df_pkg::TYPE_EVT || i_byte == hh4df_pkg::TYPE_ACL ||
                    i_byte == hh4df_pkg::TYPE_ISO) begin
                    if (i_byte == hh4df_pkg::TYPE_EVT) begin
                        n_kind = hh4df_pkg::KIND_EVT;
                    end else if (i_byte == hh4df_pkg::TYPE_ACL) begin
                        n_kind = hh4df_pkg::KIND_ACL;
                    end else begin
                        n_kind = hh4df_pkg::KIND_ISO;
                    end
                    res.frame_kind     = n_kind;
                    res.first_of_frame = 1'b1;
                    n_phase     = PH_HEADER;
                    n_hdr_idx   = '0;
                    n_len_lo    = '0;
                    n_remaining = '0;
                    n_pay_idx   = '0;
                    n_evt_code  = '0;
                    n_opcode    = '0;
                    n_status    = '0;
                    n_verdict   = hh4df_pkg::V_DELIVER;
                end
            end
        endcase

        if (res.last_of_frame) begin
            res.verdict          = n_verdict;
            res.recovery_request = (r_kind == hh4df_pkg::KIND_EVT) &&
                                   (n_evt_code == hh4df_pkg::EVC_HW_ERROR) &&
                                   (n_verdict == hh4df_pkg::V_DROP);
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TYPE;
            r_kind   <= hh4df_pkg::KIND_JUNK;
            r_rec_en <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_rec_en <= i_cfg_wr_data;
            end
            if (i_accept) begin
                r_phase <= n_phase;
                r_kind  <= n_kind;
            end
        end
    end

    // frame fields, all loaded on the type byte before use
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_hdr_idx   <= n_hdr_idx;
            r_len_lo    <= n_len_lo;
            r_remaining <= n_remaining;
            r_pay_idx   <= n_pay_idx;
            r_evt_code  <= n_evt_code;
            r_opcode    <= n_opcode;
            r_status    <= n_status;
            r_verdict   <= n_verdict;
        end
    end

endmodule

// ===== rtl/hci_h4_deframer_event_filter.sv =====
// Takes the H4 byte stream one byte per cycle while the skid entry is free and returns
// one tagged byte per input byte through the output and skid registers. Parse state is
// updated once per byte; the two-entry buffer takes one more byte while a result waits.
// depends on hh4df_pkg and hh4df_parser
`timescale 1ns / 1ps

module hci_h4_deframer_event_filter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,     // hw_error_recovery_enable
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,      // [7:0] in_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,      // [7:0] out_byte
    output logic       m_axis_tlast,      // last_of_frame
    output logic [7:0] m_axis_tuser       // [1:0] frame_kind, [2] first_of_frame,
                                          // [4:3] verdict, [5] recovery_request
);

    logic               accept;
    hh4df_pkg::t_result result;

    hh4df_pkg::t_result r_out, r_skid;
    logic               r_out_valid, r_skid_valid;
    logic               out_free;

    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    hh4df_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_byte       (s_axis_tdata),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid  <= r_skid_valid || accept;
                r_skid_valid <= 1'b0;
            end else if (accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= result;
            end
        end else if (accept) begin
            r_skid <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.out_byte;
    assign m_axis_tlast  = r_out.last_of_frame;
    assign m_axis_tuser  = {2'b00, r_out.recovery_request, r_out.verdict,
                            r_out.first_of_frame, r_out.frame_kind};

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench for hci_h4_deframer_event_filter: H4 byte streams in,
// one tagged byte out per transfer, checked against a cycle-free deframer model kept here
// depends on hh4df_pkg and the rtl of the block
`timescale 1ns / 1ps

module tb_top;

    typedef enum logic [1:0] {
        SEEK_TYPE  = 2'd0,
        IN_HEADER  = 2'd1,
        IN_PAYLOAD = 2'd2
    } t_parse_phase;

    localparam int          LIMIT_CYCLES = 1000000;
    localparam int          MAX_REPORTS  = 10;
    localparam logic [7:0]  DISCARD_SUBS [5] = '{8'h0B, 8'h13, 8'h0D, 8'h0F, 8'h25};
    localparam logic [7:0]  SUB_CONN_DONE = 8'h01;
    localparam logic [15:0] OPC_RESET     = 16'h0C03;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_wr_en = 1'b0;
    logic       i_cfg_wr_data = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic [7:0] m_axis_tuser;

    logic [7:0]          h4_stream_q[$];
    hh4df_pkg::t_result  tagged_bytes_q[$];
    logic [7:0]          evt_params[$];

    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    logic rx_hold = 1'b0;
    int  mismatch_cnt = 0;
    int  result_cnt = 0;
    int  cycle_cnt = 0;

    // deframer model state
    logic                recovery_en;
    t_parse_phase        parse_ph;
    hh4df_pkg::t_kind    cur_kind;
    logic [2:0]          hdr_pos;
    logic [7:0]          len_lo;
    logic [15:0]         bytes_left;
    logic [3:0]          pay_pos;
    logic [7:0]          evt_code;
    logic [15:0]         opcode;
    logic [7:0]          reply_status;
    hh4df_pkg::t_verdict frm_verdict;

    hci_h4_deframer_event_filter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic clear_deframer;
        recovery_en  = 1'b0;
        parse_ph     = SEEK_TYPE;
        cur_kind     = hh4df_pkg::KIND_JUNK;
        hdr_pos      = '0;
        len_lo       = '0;
        bytes_left   = '0;
        pay_pos      = '0;
        evt_code     = '0;
        opcode       = '0;
        reply_status = '0;
        frm_verdict  = hh4df_pkg::V_DELIVER;
    endtask

    task automatic deframe_byte(input logic [7:0] b, output hh4df_pkg::t_result r);
        logic        hdr_done;
        logic [15:0] flen;
        logic        discard_sub;
        r = '0;
        r.out_byte = b;
        r.frame_kind = hh4df_pkg::KIND_JUNK;
        r.verdict = hh4df_pkg::V_DELIVER;
        hdr_done = 1'b0;
        flen = '0;
        case (parse_ph)
            IN_HEADER: begin
                r.frame_kind = cur_kind;
                if (cur_kind == hh4df_pkg::KIND_EVT) begin
                    if (hdr_pos == hh4df_pkg::HDR_CODE) begin
                        evt_code = b;
                        frm_verdict = (b == hh4df_pkg::EVC_HW_ERROR && recovery_en) ?
                                      hh4df_pkg::V_DROP : hh4df_pkg::V_DELIVER;
                    end else begin
                        flen = {8'h00, b};
                        hdr_done = 1'b1;
                    end
                end else if (hdr_pos == hh4df_pkg::HDR_LEN_LO) begin
                    len_lo = b;
                end else if (hdr_pos >= hh4df_pkg::HDR_LEN_HI) begin
                    flen = {b, len_lo};
                    if (cur_kind == hh4df_pkg::KIND_ISO)
                        flen[15:14] = 2'b00;
                    hdr_done = 1'b1;
                end
                hdr_pos = hdr_pos + 3'd1;
                if (hdr_done) begin
                    bytes_left = flen;
                    pay_pos = '0;
                    if (flen == 16'd0) begin
                        r.last_of_frame = 1'b1;
                        parse_ph = SEEK_TYPE;
                    end else begin
                        parse_ph = IN_PAYLOAD;
                    end
                end
            end
            IN_PAYLOAD: begin
                r.frame_kind = cur_kind;
                if (cur_kind == hh4df_pkg::KIND_EVT) begin
                    if (evt_code == hh4df_pkg::EVC_LE_META &&
                        pay_pos == hh4df_pkg::IDX_SUBEVENT) begin
                        discard_sub = 1'b0;
                        foreach (DISCARD_SUBS[i])
                            if (b == DISCARD_SUBS[i])
                                discard_sub = 1'b1;
                        if (discard_sub)
                            frm_verdict = hh4df_pkg::V_DISCARD;
                    end else if (evt_code == hh4df_pkg::EVC_CMD_COMP) begin
                        if (pay_pos == hh4df_pkg::IDX_OP_LSB) begin
                            opcode[7:0] = b;
                        end else if (pay_pos == hh4df_pkg::IDX_OP_MSB) begin
                            opcode[15:8] = b;
                            if (opcode == hh4df_pkg::OPC_NOP)
                                frm_verdict = hh4df_pkg::V_DROP;
                        end else if (pay_pos == hh4df_pkg::IDX_STATUS) begin
                            reply_status = b;
                        end else if (pay_pos == hh4df_pkg::IDX_FEAT4 &&
                                     opcode == hh4df_pkg::OPC_READ_FEAT &&
                                     reply_status == hh4df_pkg::STATUS_OK) begin
                            r.out_byte = b | hh4df_pkg::FEAT_PATCH;
                        end
                    end
                end
                if (pay_pos != hh4df_pkg::IDX_MAX)
                    pay_pos = pay_pos + 4'd1;
                bytes_left = bytes_left - 16'd1;
                if (bytes_left == 16'd0) begin
                    r.last_of_frame = 1'b1;
                    parse_ph = SEEK_TYPE;
                end
            end
            default: begin
                parse_ph = SEEK_TYPE;
                if (b == hh4df_pkg::TYPE_EVT || b == hh4df_pkg::TYPE_ACL ||
                    b == hh4df_pkg::TYPE_ISO) begin
                    cur_kind = (b == hh4df_pkg::TYPE_EVT) ? hh4df_pkg::KIND_EVT :
                               (b == hh4df_pkg::TYPE_ACL) ? hh4df_pkg::KIND_ACL :
                                                            hh4df_pkg::KIND_ISO;
                    r.frame_kind = cur_kind;
                    r.first_of_frame = 1'b1;
                    parse_ph = IN_HEADER;
                    hdr_pos = '0;
                    len_lo = '0;
                    bytes_left = '0;
                    pay_pos = '0;
                    evt_code = '0;
                    opcode = '0;
                    reply_status = '0;
                    frm_verdict = hh4df_pkg::V_DELIVER;
                end
            end
        endcase
        if (r.last_of_frame) begin
            r.verdict = frm_verdict;
            r.recovery_request = (cur_kind == hh4df_pkg::KIND_EVT &&
                                  evt_code == hh4df_pkg::EVC_HW_ERROR &&
                                  frm_verdict == hh4df_pkg::V_DROP);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (h4_stream_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= h4_stream_q.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end

    // monitor: model update on each input transfer, check on each output transfer
    always @(posedge i_clk) begin
        hh4df_pkg::t_result want;
        hh4df_pkg::t_result got;
        if (!i_rst_n) begin
            clear_deframer();
        end else begin
            if (i_cfg_wr_en)
                recovery_en = i_cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready) begin
                deframe_byte(s_axis_tdata, want);
                tagged_bytes_q.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.out_byte         = m_axis_tdata;
                got.frame_kind       = hh4df_pkg::t_kind'(m_axis_tuser[1:0]);
                got.first_of_frame   = m_axis_tuser[2];
                got.last_of_frame    = m_axis_tlast;
                got.verdict          = hh4df_pkg::t_verdict'(m_axis_tuser[4:3]);
                got.recovery_request = m_axis_tuser[5];
                if (tagged_bytes_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("unexpected transfer %0d: byte %h user %h last %b",
                                 result_cnt, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end else begin
                    want = tagged_bytes_q.pop_front();
                    if (got.out_byte !== want.out_byte || got.frame_kind !== want.frame_kind ||
                        got.first_of_frame !== want.first_of_frame ||
                        got.last_of_frame !== want.last_of_frame ||
                        got.verdict !== want.verdict ||
                        got.recovery_request !== want.recovery_request) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS)
                            $display({"mismatch at transfer %0d: exp byte %h kind %0d first %b ",
                                      "last %b verdict %0d rec %b, got byte %h kind %0d ",
                                      "first %b last %b verdict %0d rec %b"}, result_cnt,
                                     want.out_byte, want.frame_kind, want.first_of_frame,
                                     want.last_of_frame, want.verdict, want.recovery_request,
                                     got.out_byte, got.frame_kind, got.first_of_frame,
                                     got.last_of_frame, got.verdict, got.recovery_request);
                    end
                end
                result_cnt++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic set_recovery(input logic v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain;
        while (h4_stream_q.size() != 0 || s_axis_tvalid || tagged_bytes_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic put_event(input logic [7:0] code);
        h4_stream_q.push_back(hh4df_pkg::TYPE_EVT);
        h4_stream_q.push_back(code);
        h4_stream_q.push_back(8'(evt_params.size()));
        foreach (evt_params[i])
            h4_stream_q.push_back(evt_params[i]);
        evt_params.delete();
    endtask

    task automatic put_data(input logic [7:0] typ, input logic [15:0] len_field);
        logic [15:0] handle;
        int          n;
        handle = 16'($urandom);
        n = (typ == hh4df_pkg::TYPE_ISO) ? int'(len_field & 16'h3FFF) : int'(len_field);
        h4_stream_q.push_back(typ);
        h4_stream_q.push_back(handle[7:0]);
        h4_stream_q.push_back(handle[15:8]);
        h4_stream_q.push_back(len_field[7:0]);
        h4_stream_q.push_back(len_field[15:8]);
        repeat (n) h4_stream_q.push_back(8'($urandom));
    endtask

    // command complete: packets, opcode, status, then feature octets
    task automatic fill_cmd_comp(input logic [15:0] op, input logic [7:0] status, input int n);
        evt_params.push_back(8'($urandom));
        evt_params.push_back(op[7:0]);
        evt_params.push_back(op[15:8]);
        evt_params.push_back(status);
        repeat (8) evt_params.push_back(8'($urandom));
        while (evt_params.size() > n) void'(evt_params.pop_back());
        while (evt_params.size() < n) evt_params.push_back(8'($urandom));
    endtask

    task automatic rand_event;
        logic [15:0] op;
        logic [7:0]  code;
        int          n;
        case ($urandom_range(9))
            0, 1, 2: begin
                case ($urandom_range(3))
                    0: op = hh4df_pkg::OPC_NOP;
                    1, 2: op = hh4df_pkg::OPC_READ_FEAT;
                    default: op = 16'($urandom);
                endcase
                case ($urandom_range(3))
                    0: n = $urandom_range(11);
                    3: n = $urandom_range(20);
                    default: n = 12;
                endcase
                fill_cmd_comp(op, ($urandom_range(3) == 0) ? 8'($urandom) :
                                                             hh4df_pkg::STATUS_OK, n);
                put_event(hh4df_pkg::EVC_CMD_COMP);
            end
            3, 4: begin
                n = $urandom_range(16);
                if (n != 0)
                    evt_params.push_back(($urandom_range(2) != 0) ?
                                         DISCARD_SUBS[$urandom_range(4)] : 8'($urandom));
                repeat (n - evt_params.size()) evt_params.push_back(8'($urandom));
                put_event(hh4df_pkg::EVC_LE_META);
            end
            5: begin
                n = ($urandom_range(3) == 0) ? $urandom_range(2) : 1;
                repeat (n) evt_params.push_back(8'($urandom));
                put_event(hh4df_pkg::EVC_HW_ERROR);
            end
            default: begin
                code = 8'($urandom);
                n = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(12);
                repeat (n) evt_params.push_back(8'($urandom));
                put_event(code);
            end
        endcase
    endtask

    task automatic rand_frame;
        int          r;
        logic [15:0] len_field;
        r = $urandom_range(99);
        if (r < 45) begin
            rand_event();
        end else if (r < 65) begin
            len_field = ($urandom_range(24) == 0) ? 16'($urandom_range(300)) :
                                                    16'($urandom_range(12));
            put_data(hh4df_pkg::TYPE_ACL, len_field);
        end else if (r < 80) begin
            len_field = {2'($urandom), 14'($urandom_range(12))};
            put_data(hh4df_pkg::TYPE_ISO, len_field);
        end else if (r < 90) begin
            repeat ($urandom_range(1, 3)) h4_stream_q.push_back(8'($urandom));
        end else begin
            // broken frame: header cut short, the next frame's bytes get swallowed
            h4_stream_q.push_back(($urandom_range(1) != 0) ? hh4df_pkg::TYPE_EVT :
                                                             hh4df_pkg::TYPE_ACL);
            repeat ($urandom_range(1, 3)) h4_stream_q.push_back(8'($urandom_range(8)));
        end
    endtask

    task automatic rand_phase(input int n);
        while (h4_stream_q.size() < n)
            rand_frame();
    endtask

    task automatic directed_frames;
        foreach (DISCARD_SUBS[i]) begin
            evt_params.push_back(DISCARD_SUBS[i]);
            evt_params.push_back(8'($urandom));
            put_event(hh4df_pkg::EVC_LE_META);
        end
        evt_params.push_back(SUB_CONN_DONE);
        put_event(hh4df_pkg::EVC_LE_META);
        put_event(hh4df_pkg::EVC_LE_META);                    // ends before the subevent
        fill_cmd_comp(hh4df_pkg::OPC_NOP, hh4df_pkg::STATUS_OK, 4);
        put_event(hh4df_pkg::EVC_CMD_COMP);
        // ends before the opcode high byte
        fill_cmd_comp(hh4df_pkg::OPC_NOP, hh4df_pkg::STATUS_OK, 2);
        put_event(hh4df_pkg::EVC_CMD_COMP);
        fill_cmd_comp(hh4df_pkg::OPC_READ_FEAT, hh4df_pkg::STATUS_OK, 12);
        evt_params[8] = 8'h00;
        put_event(hh4df_pkg::EVC_CMD_COMP);
        fill_cmd_comp(hh4df_pkg::OPC_READ_FEAT, hh4df_pkg::STATUS_OK, 12);
        evt_params[8] = 8'h9F;
        put_event(hh4df_pkg::EVC_CMD_COMP);
        fill_cmd_comp(hh4df_pkg::OPC_READ_FEAT, 8'h0C, 12);   // failed reply, no patch
        put_event(hh4df_pkg::EVC_CMD_COMP);
        // ends before feature octet 4
        fill_cmd_comp(hh4df_pkg::OPC_READ_FEAT, hh4df_pkg::STATUS_OK, 8);
        put_event(hh4df_pkg::EVC_CMD_COMP);
        fill_cmd_comp(OPC_RESET, hh4df_pkg::STATUS_OK, 4);
        put_event(hh4df_pkg::EVC_CMD_COMP);
        evt_params.push_back(8'h42);
        put_event(hh4df_pkg::EVC_HW_ERROR);
        put_event(hh4df_pkg::EVC_HW_ERROR);
        put_event(8'hFF);
        put_data(hh4df_pkg::TYPE_ACL, 16'h0000);
        put_data(hh4df_pkg::TYPE_ACL, 16'h0005);
        put_data(hh4df_pkg::TYPE_ISO, 16'hC000);              // masked to zero length
        put_data(hh4df_pkg::TYPE_ISO, 16'h8003);
        h4_stream_q.push_back(8'h00);
        h4_stream_q.push_back(8'hFF);
        h4_stream_q.push_back(8'h01);
        h4_stream_q.push_back(8'h03);
        h4_stream_q.push_back(8'h06);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        set_recovery(1'b0);
        directed_frames();
        drain();

        set_recovery(1'b1);
        directed_frames();
        put_data(hh4df_pkg::TYPE_ACL, 16'h0110);
        put_data(hh4df_pkg::TYPE_ISO, 16'hC018);
        rand_phase(150);
        drain();

        set_recovery(1'b0);
        tx_idle_pct = 57;
        rand_phase(250);
        drain();

        set_recovery(1'b1);
        tx_idle_pct = 0;
        rx_stall_pct = 57;
        rand_phase(250);
        drain();

        set_recovery(1'b0);
        tx_idle_pct = 19;
        rx_stall_pct = 19;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (300) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        join_none
        rand_phase(150);
        drain();
        rand_phase(150);
        drain();

        set_recovery(1'b1);
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        rand_phase(50);
        drain();

        repeat (20) @(posedge i_clk);
        if (mismatch_cnt == 0 && tagged_bytes_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
